// ===== design/htrk_pkg.sv =====
// Shared types, widths and the arctangent table for the heading tracker.
package htrk_pkg;

	localparam int XY_W              = 34;	// CORDIC x/y datapath, covers gain growth
	localparam int ANG_W             = 32;	// angle accumulator, 2^32 = full turn
	localparam int HDG_W             = 16;	// binary angle measure of one heading
	localparam int TURN_W            = 24;	// signed applied turn
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 24;	// deepest chain the table supports

	localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [ANG_W-1:0] ROUND_HALF   = 32'h0000_8000;
	localparam logic [HDG_W-1:0] QUARTER_TURN = 16'h4000;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic [ANG_W-1:0]       acc;
	} cord_t;

	// Item fields that ride alongside the rotation chain
	typedef struct packed {
		logic             op;
		logic             zero;	// both differences were zero
		logic [HDG_W-1:0] target_heading;
		logic [HDG_W-1:0] current_heading;
		logic [HDG_W-1:0] frame_time;
	} side_t;

	function automatic logic [ANG_W-1:0] atan_tab(input logic [4:0] idx);
		logic [ANG_W-1:0] v;
		unique case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/heading_tracker_step.sv =====
// Top level of the heading tracker: input stage, CORDIC cell chain and post stages.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one beat per item: op, the two points,
//   target_heading, current_heading and frame_time. Output channel (out_valid /
//   out_stall) returns one beat per item with new_heading, applied_turn and
//   target_angle, in the order the items were taken.
//   Throughput is one item per clock cycle unless the output stalls. There is one
//   input register, one register per CORDIC cell and four post stages (angle and
//   difference, two multiplies, rounding and update). rotation_speed is written with
//   rotation_speed_we / rotation_speed_wdata; the user must write it only while no
//   item is in flight, not checked by the block. Zero snaps straight to the target.
//   Reset (arst_n low) empties the pipeline and clears rotation_speed to zero.
//   When the receiver stalls with a beat waiting, the whole pipeline holds and
//   in_stall rises in the same cycle; bubbles are not squeezed out.
//   CORDIC_STAGES may range from 8 to 24.
module heading_tracker_step #(
	parameter int CORDIC_STAGES = htrk_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                rotation_speed_we,
	input  logic [15:0]                         rotation_speed_wdata,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [15:0]                  from_x,
	input  logic signed [15:0]                  from_y,
	input  logic signed [15:0]                  to_x,
	input  logic signed [15:0]                  to_y,
	input  logic [htrk_pkg::HDG_W-1:0]          target_heading,
	input  logic [htrk_pkg::HDG_W-1:0]          current_heading,
	input  logic [15:0]                         frame_time,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [htrk_pkg::HDG_W-1:0]          new_heading,
	output logic signed [htrk_pkg::TURN_W-1:0]  applied_turn,
	output logic [htrk_pkg::HDG_W-1:0]          target_angle
);

	localparam int XW = htrk_pkg::XY_W;

	logic [15:0] rotation_speed_q;

	// Whole pipeline advances together unless a finished beat is held at the output
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_speed_q <= '0;
		end else if (rotation_speed_we) begin
			rotation_speed_q <= rotation_speed_wdata;
		end
	end

	// Differences are exact in 17 bits; scale by 2^14 and fold the left half-plane
	// onto the right by negating the vector and starting half a turn round.
	logic signed [16:0] dx, dy;
	logic signed [XW-1:0] xs, ys;
	htrk_pkg::cord_t cord_pre;
	htrk_pkg::side_t side_pre;

	always_comb begin
		dx = {to_x[15], to_x} - {from_x[15], from_x};
		dy = {to_y[15], to_y} - {from_y[15], from_y};
		xs = {{(XW-31){dx[16]}}, dx, 14'b0};
		ys = {{(XW-31){dy[16]}}, dy, 14'b0};
		if (dx[16]) begin
			cord_pre.x   = -xs;
			cord_pre.y   = -ys;
			cord_pre.acc = htrk_pkg::HALF_TURN;
		end else begin
			cord_pre.x   = xs;
			cord_pre.y   = ys;
			cord_pre.acc = '0;
		end
		side_pre.op              = op;
		side_pre.zero            = (dx == '0) && (dy == '0);
		side_pre.target_heading  = target_heading;
		side_pre.current_heading = current_heading;
		side_pre.frame_time      = frame_time;
	end

	// Chain links: index 0 is the input register, index k the output of cell k-1
	logic            vld_c  [0:CORDIC_STAGES];
	htrk_pkg::cord_t cord_c [0:CORDIC_STAGES];
	htrk_pkg::side_t side_c [0:CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else if (en) begin
			vld_c[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cord_c[0] <= cord_pre;
			side_c[0] <= side_pre;
		end
	end

	// Row of micro-rotation cells, each shifting by its own position
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
		htrk_cell #(
			.IDX (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_c[k]),
			.cord_i (cord_c[k]),
			.side_i (side_c[k]),
			.vld_o  (vld_c[k+1]),
			.cord_o (cord_c[k+1]),
			.side_o (side_c[k+1])
		);
	end

	// Round the angle, take the shortest turn, scale it and update the heading
	htrk_post u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.vld_i        (vld_c[CORDIC_STAGES]),
		.cord_i       (cord_c[CORDIC_STAGES]),
		.side_i       (side_c[CORDIC_STAGES]),
		.speed        (rotation_speed_q),
		.out_valid    (out_valid),
		.new_heading  (new_heading),
		.applied_turn (applied_turn),
		.target_angle (target_angle)
	);

endmodule

// ===== design/htrk_cell.sv =====
// One CORDIC vectoring cell: a micro-rotation by a fixed shift, registered.
module htrk_cell #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_i,
	input  htrk_pkg::cord_t      cord_i,
	input  htrk_pkg::side_t      side_i,
	output logic                 vld_o,
	output htrk_pkg::cord_t      cord_o,
	output htrk_pkg::side_t      side_o
);

	localparam logic [htrk_pkg::ANG_W-1:0] ATAN_STEP = htrk_pkg::atan_tab(5'(IDX));

	logic signed [htrk_pkg::XY_W-1:0] shx;
	logic signed [htrk_pkg::XY_W-1:0] shy;
	htrk_pkg::cord_t                  nxt;

	// Arithmetic shifts round toward minus infinity
	assign shx = $signed(cord_i.x) >>> IDX;
	assign shy = $signed(cord_i.y) >>> IDX;

	always_comb begin
		if (!cord_i.y[htrk_pkg::XY_W-1]) begin
			nxt.x   = cord_i.x + shy;
			nxt.y   = cord_i.y - shx;
			nxt.acc = cord_i.acc + ATAN_STEP;
		end else begin
			nxt.x   = cord_i.x - shy;
			nxt.y   = cord_i.y + shx;
			nxt.acc = cord_i.acc - ATAN_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cord_o <= nxt;
			side_o <= side_i;
		end
	end

endmodule

// ===== design/htrk_post.sv =====
// Angle rounding, shortest turn, speed scaling and heading update (four stages).
module htrk_post (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_i,
	input  htrk_pkg::cord_t                     cord_i,
	input  htrk_pkg::side_t                     side_i,
	input  logic [15:0]                         speed,
	output logic                                out_valid,
	output logic [htrk_pkg::HDG_W-1:0]          new_heading,
	output logic signed [htrk_pkg::TURN_W-1:0]  applied_turn,
	output logic [htrk_pkg::HDG_W-1:0]          target_angle
);

	localparam int HW = htrk_pkg::HDG_W;
	localparam int TW = htrk_pkg::TURN_W;

	// stage 1: rounded angle, target, signed difference
	logic [htrk_pkg::ANG_W-1:0] acc_rnd;
	logic [HW-1:0]              ang;
	logic [HW-1:0]              tgt;

	logic                       vld_s1, op_s1, zero_s1, spz_s1;
	logic [HW-1:0]              tgt_s1, cur_s1, frm_s1, diff_s1;

	always_comb begin
		acc_rnd = cord_i.acc + htrk_pkg::ROUND_HALF;
		ang     = side_i.zero ? '0 : acc_rnd[htrk_pkg::ANG_W-1 -: HW];
		tgt     = side_i.op ? side_i.target_heading : (ang - htrk_pkg::QUARTER_TURN);
	end

	// stage 2: magnitude times speed
	logic [HW-1:0]   mag;
	logic            vld_s2, op_s2, zero_s2, spz_s2, neg_s2;
	logic [HW-1:0]   tgt_s2, cur_s2, frm_s2, diff_s2;
	logic [2*HW-1:0] prod1_s2;

	assign mag = diff_s1[HW-1] ? (~diff_s1 + HW'(1)) : diff_s1;

	// stage 3: times frame time
	logic            vld_s3, op_s3, zero_s3, spz_s3, neg_s3;
	logic [HW-1:0]   tgt_s3, cur_s3, diff_s3;
	logic [3*HW-1:0] prod2_s3;

	// stage 4: round, sign and add
	logic [3*HW:0]   p_rnd;
	logic [TW-1:0]   r_mag;
	logic [TW-1:0]   turn;
	logic            op_q, zero_q, spz_q, neg_q;

	always_comb begin
		p_rnd = {1'b0, prod2_s3} + (49'd1 << (TW - 1));
		r_mag = p_rnd[2*TW-1:TW];
		if (spz_s3) begin
			turn = {{(TW-HW){diff_s3[HW-1]}}, diff_s3};
		end else if (neg_s3) begin
			turn = ~r_mag + TW'(1);
		end else begin
			turn = r_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= vld_i;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			out_valid <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= side_i.op;
			zero_s1  <= side_i.zero;
			spz_s1   <= (speed == '0);
			tgt_s1   <= tgt;
			cur_s1   <= side_i.current_heading;
			frm_s1   <= side_i.frame_time;
			diff_s1  <= tgt - side_i.current_heading;

			op_s2    <= op_s1;
			zero_s2  <= zero_s1;
			spz_s2   <= spz_s1;
			neg_s2   <= diff_s1[HW-1];
			tgt_s2   <= tgt_s1;
			cur_s2   <= cur_s1;
			frm_s2   <= frm_s1;
			diff_s2  <= diff_s1;
			prod1_s2 <= (2*HW)'(mag) * (2*HW)'(speed);

			op_s3    <= op_s2;
			zero_s3  <= zero_s2;
			spz_s3   <= spz_s2;
			neg_s3   <= neg_s2;
			tgt_s3   <= tgt_s2;
			cur_s3   <= cur_s2;
			diff_s3  <= diff_s2;
			prod2_s3 <= (3*HW)'(prod1_s2) * (3*HW)'(frm_s2);

			op_q         <= op_s3;
			zero_q       <= zero_s3;
			spz_q        <= spz_s3;
			neg_q        <= neg_s3;
			target_angle <= tgt_s3;
			applied_turn <= turn;
			new_heading  <= cur_s3 + turn[HW-1:0];
		end
	end

	// snap mode lands exactly on the target
	a_snap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && spz_q |-> new_heading == target_angle)
		else $error("snap turn missed the target");

	// coincident points aim a quarter turn back from zero
	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_q && !op_q |-> target_angle == 16'hC000)
		else $error("coincident points gave wrong target");

	// a scaled turn of a non-negative difference is never negative
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !spz_q && !neg_q |-> !applied_turn[TW-1])
		else $error("scaled turn changed sign");

	// a held pipeline keeps its partial products
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en && vld_s3 |=> $stable(prod2_s3))
		else $error("partial product moved while held");

endmodule
